>>> hw/rtl/glcd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the graphic LCD framebuffer refresh scanner.
// No dependencies; imported by the scan sequencer and the top level.
package glcd_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    // Chip select codes
    localparam logic [1:0] SEL_FIRST  = 2'd0;
    localparam logic [1:0] SEL_SECOND = 2'd1;
    localparam logic [1:0] SEL_BOTH   = 2'd2;

    // Panel command codes
    localparam logic [7:0] CMD_PAGE = 8'hB8;
    localparam logic [7:0] CMD_ADDR = 8'h40;

    localparam int ROWS_PER_PAGE = 8;
    localparam int ROW_BIT_W     = 3;

    // Per-tick result as worked out by the scan sequencer
    typedef struct packed {
        logic       is_data;    // byte comes from the framebuffer
        logic [7:0] cmd_byte;   // command byte for the set-page / set-address phases
        logic       data_mode;
        logic [1:0] chip_sel;
        logic       backlight;
    } scan_info_t;

endpackage

>>> hw/rtl/glcd_framebuffer_refresh_scanner.sv
`timescale 1ns / 1ps
// Top level of the graphic LCD framebuffer refresh scanner.
// Depends on glcd_pkg, glcd_ram and glcd_scan.
//
// The block holds a byte framebuffer (one byte per column and page, bit b is row
// page*8+b) in a single RAM and serves three kinds of input item, chosen by
// s_tuser: a refresh tick, a pixel write and a clear. A refresh tick gives one
// result item, the next LCD bus transfer of a fixed scan: COLS_PER_CHIP data
// bytes, then set-page (DI low; the page and, after the last page, the chip
// advance here), then set-address 0x40; DI returns high after that. The
// backlight PWM counter steps on every tick and its level after the step rides
// with the result. Pixel writes outside the panel and the unused request code
// are dropped. A tick reads the RAM and then loads the result into the output
// register, waiting in between only while the previous result sits untaken in
// that register; a pixel write reads the RAM and then writes the byte back; an
// ignored one is dropped on acceptance. A clear sweeps the RAM one entry per
// cycle over all STORE_DEPTH entries (1024 at defaults), and the same sweep runs
// after reset; s_tready stays low throughout. The brightness register may be
// written at any time but should be changed only while the block is idle.
module glcd_framebuffer_refresh_scanner import glcd_pkg::*; #(
    parameter int COLS_PER_CHIP = 64,
    parameter int NUM_CHIPS     = 2,
    parameter int NUM_PAGES     = 8,
    parameter int PWM_MAX       = 32,
    parameter int PWM_MIN       = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] pixel_x, [14:8] pixel_y, [15] pixel_on
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] bus_byte, [9:8] chip_select, [10] backlight_on,
                                   // [15:11] zero
    output logic        m_tuser,   // [0] data_mode
    // brightness register
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);

    localparam int TOTAL_COLS  = COLS_PER_CHIP * NUM_CHIPS;
    localparam int STORE_DEPTH = TOTAL_COLS * NUM_PAGES;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,   // zeroing sweep
        ST_IDLE  = 4'b0010,   // ready for an item
        ST_PIXEL = 4'b0100,   // read data back, write modified byte
        ST_TICK  = 4'b1000    // read data back, load output register
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [4:0]            brightness_reg;

    // pixel write held across the read-modify-write
    logic [AW-1:0]         pix_addr_reg, pix_addr_next;
    logic [ROW_BIT_W-1:0]  pix_bit_reg, pix_bit_next;
    logic                  pix_on_reg, pix_on_next;

    // tick result waiting for the RAM data
    scan_info_t            pend_reg, pend_next;

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  out_dm_reg, out_dm_next;
    logic [1:0]            out_cs_reg, out_cs_next;
    logic                  out_bl_reg, out_bl_next;

    logic                  in_acc;
    req_type_t             req;
    logic [7:0]            pix_x;
    logic [6:0]            pix_y;
    logic                  pix_in_range;
    logic [AW-1:0]         pix_addr;
    logic [7:0]            pix_mask;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [7:0]            ram_wdata, ram_rdata;

    logic                  scan_tick;
    scan_info_t            scan_info;
    logic [AW-1:0]         scan_addr;
    logic                  out_load;

    glcd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    glcd_scan #(
        .COLS_PER_CHIP (COLS_PER_CHIP),
        .NUM_CHIPS     (NUM_CHIPS),
        .NUM_PAGES     (NUM_PAGES),
        .PWM_MAX       (PWM_MAX),
        .PWM_MIN       (PWM_MIN),
        .AW            (AW)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (scan_tick),
        .brightness (brightness_reg),
        .info       (scan_info),
        .rd_addr    (scan_addr)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign req      = req_type_t'(s_tuser);
    assign pix_x    = s_tdata[7:0];
    assign pix_y    = s_tdata[14:8];

    assign pix_in_range = (32'(pix_x) < TOTAL_COLS) && (32'(pix_y) < NUM_PAGES * ROWS_PER_PAGE);
    assign pix_addr     = AW'(pix_x) * AW'(NUM_PAGES) + AW'(pix_y[6:ROW_BIT_W]);
    assign pix_mask     = 8'(1) << pix_bit_reg;

    assign scan_tick = in_acc && (req == REQ_TICK);

    // result leaves ST_TICK once the output register is free or being emptied
    assign out_load = (state_reg == ST_TICK) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        pix_addr_next = pix_addr_reg;
        pix_bit_next  = pix_bit_reg;
        pix_on_next   = pix_on_reg;
        pend_next     = pend_reg;
        ram_re        = 1'b0;
        ram_raddr     = scan_addr;
        ram_we        = 1'b0;
        ram_waddr     = clr_cnt_reg;
        ram_wdata     = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR) begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (req)
                        REQ_TICK: begin
                            ram_re     = 1'b1;
                            pend_next  = scan_info;
                            state_next = ST_TICK;
                        end
                        REQ_PIXEL: begin
                            if (pix_in_range) begin
                                ram_re        = 1'b1;
                                ram_raddr     = pix_addr;
                                pix_addr_next = pix_addr;
                                pix_bit_next  = pix_y[ROW_BIT_W-1:0];
                                pix_on_next   = s_tdata[15];
                                state_next    = ST_PIXEL;
                            end
                        end
                        REQ_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PIXEL: begin
                ram_we     = 1'b1;
                ram_waddr  = pix_addr_reg;
                ram_wdata  = pix_on_reg ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
                state_next = ST_IDLE;
            end
            ST_TICK: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_byte_next = out_byte_reg;
        out_dm_next   = out_dm_reg;
        out_cs_next   = out_cs_reg;
        out_bl_next   = out_bl_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            out_byte_next = pend_reg.is_data ? ram_rdata : pend_reg.cmd_byte;
            out_dm_next   = pend_reg.data_mode;
            out_cs_next   = pend_reg.chip_sel;
            out_bl_next   = pend_reg.backlight;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            brightness_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                brightness_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pix_addr_reg <= pix_addr_next;
        pix_bit_reg  <= pix_bit_next;
        pix_on_reg   <= pix_on_next;
        pend_reg     <= pend_next;
        out_byte_reg <= out_byte_next;
        out_dm_reg   <= out_dm_next;
        out_cs_reg   <= out_cs_next;
        out_bl_reg   <= out_bl_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_bl_reg, out_cs_reg, out_byte_reg};
    assign m_tuser  = out_dm_reg;

    // a read and a write never share a cycle, so no forwarding is needed
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("store read and write in the same cycle");

    a_tick_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == REQ_TICK) |=> (state_reg == ST_TICK))
        else $error("accepted tick did not move to result stage");

    a_result_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_TICK))
        else $error("result produced outside a tick");

    a_clear_runs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && clr_cnt_reg != LAST_ADDR) |=> (state_reg == ST_CLEAR))
        else $error("clear sweep left early");

endmodule

>>> hw/rtl/glcd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module glcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/glcd_scan.sv
`timescale 1ns / 1ps
// Scan sequencer: phase, page and chip counters, DI and chip-select state, backlight PWM.
// Depends on glcd_pkg.
module glcd_scan import glcd_pkg::*; #(
    parameter int COLS_PER_CHIP = 64,
    parameter int NUM_CHIPS     = 2,
    parameter int NUM_PAGES     = 8,
    parameter int PWM_MAX       = 32,
    parameter int PWM_MIN       = 0,
    parameter int AW            = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          tick,
    input  logic [4:0]    brightness,
    output scan_info_t    info,
    output logic [AW-1:0] rd_addr
);

    localparam int PHW  = $clog2(COLS_PER_CHIP + 2);
    localparam int PGW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CHW  = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
    localparam int PCW  = $clog2(PWM_MAX);
    localparam int CMPW = (PCW > 5) ? PCW : 5;
    localparam logic [PHW-1:0] PHASE_PAGE = PHW'(COLS_PER_CHIP);
    localparam logic [PHW-1:0] PHASE_ADDR = PHW'(COLS_PER_CHIP + 1);

    logic [PHW-1:0] phase_reg, phase_next;
    logic [PGW-1:0] page_reg, page_next;
    logic [CHW-1:0] chip_reg, chip_next;
    logic [1:0]     cs_reg, cs_next;
    logic           dm_reg, dm_next, dm_tick;
    logic [PCW-1:0] pwm_reg, pwm_next;
    logic           bl_reg, bl_next;
    logic [PGW:0]   page_inc;
    logic [PCW:0]   pwm_inc;
    logic           at_page, at_addr;

    always_comb begin
        at_page    = (phase_reg == PHASE_PAGE);
        at_addr    = (phase_reg == PHASE_ADDR);
        page_inc   = {1'b0, page_reg} + (PGW + 1)'(1);
        page_next  = page_reg;
        chip_next  = chip_reg;
        cs_next    = cs_reg;
        dm_tick    = dm_reg;
        if (at_page) begin
            dm_tick = 1'b0;
            if (page_inc >= (PGW + 1)'(NUM_PAGES)) begin
                page_next = '0;
                chip_next = (chip_reg == CHW'(NUM_CHIPS - 1)) ? '0 : chip_reg + CHW'(1);
                cs_next   = (chip_next == CHW'(1)) ? SEL_SECOND : SEL_FIRST;
            end else begin
                page_next = page_inc[PGW-1:0];
            end
        end
        phase_next = at_addr ? '0 : phase_reg + PHW'(1);
        dm_next    = at_addr ? 1'b1 : dm_tick;

        // PWM wraps to its minimum; off at the compare value, on at zero
        pwm_inc  = {1'b0, pwm_reg} + (PCW + 1)'(1);
        pwm_next = (pwm_inc >= (PCW + 1)'(PWM_MAX)) ? PCW'(PWM_MIN) : pwm_inc[PCW-1:0];
        if (CMPW'(pwm_next) == CMPW'(brightness)) begin
            bl_next = 1'b0;
        end else if (pwm_next == '0) begin
            bl_next = 1'b1;
        end else begin
            bl_next = bl_reg;
        end

        info.is_data   = !(at_page || at_addr);
        info.cmd_byte  = at_page ? (CMD_PAGE + 8'(page_next)) : CMD_ADDR;
        info.data_mode = dm_tick;
        info.chip_sel  = cs_next;
        info.backlight = bl_next;

        // Column-major store: column * pages + page
        rd_addr = (AW'(phase_reg) + AW'(COLS_PER_CHIP) * AW'(chip_reg)) * AW'(NUM_PAGES)
                  + AW'(page_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            page_reg  <= '0;
            chip_reg  <= '0;
            cs_reg    <= SEL_BOTH;
            dm_reg    <= 1'b1;
            pwm_reg   <= '0;
            bl_reg    <= 1'b0;
        end else if (tick) begin
            phase_reg <= phase_next;
            page_reg  <= page_next;
            chip_reg  <= chip_next;
            cs_reg    <= cs_next;
            dm_reg    <= dm_next;
            pwm_reg   <= pwm_next;
            bl_reg    <= bl_next;
        end
    end

endmodule
